@@ design/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ray against box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

	// coordinate and distance formats
	localparam int CRD_W  = 32;
	localparam int FRAC_W = 16;
	localparam int DIST_W = 48;
	localparam int ABS_W  = CRD_W + 1;
	localparam int NUM_W  = ABS_W + FRAC_W;
	localparam int PROD_W = FRAC_W + DIST_W - 1;

	// pipeline depth: operand stage, one stage per quotient bit, saturation,
	// slab ordering, interval narrowing, output register
	localparam int LAT = NUM_W + 5;

	// largest distance magnitude
	localparam logic [DIST_W-2:0] DMAX = '1;

	// 1.0 in coordinate format
	localparam logic signed [CRD_W-1:0] ONE = CRD_W'(1) << FRAC_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIST_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_DIR_X     = 3'd3,
		REG_DIR_Y     = 3'd4,
		REG_DIR_Z     = 3'd5,
		REG_MAX_DIST  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] box_min_x;
		logic signed [CRD_W-1:0] box_min_y;
		logic signed [CRD_W-1:0] box_min_z;
		logic signed [CRD_W-1:0] box_max_x;
		logic signed [CRD_W-1:0] box_max_y;
		logic signed [CRD_W-1:0] box_max_z;
	} box_t;

	typedef struct packed {
		logic                     box_hit;
		logic                     hit_in_range;
		logic signed [DIST_W-1:0] t_enter;
		logic signed [DIST_W-1:0] t_exit;
	} res_t;

	// ordered crossing pair of one axis
	typedef struct packed {
		logic signed [DIST_W-1:0] t_lo;
		logic signed [DIST_W-1:0] t_hi;
	} slab_t;

endpackage

`default_nettype wire

@@ design/rbst_div.sv @@
// ----------------------------------------------------------------------------
// rbst_div
// Slab crossing distance of one corner: pipelined restoring divider, one
// quotient bit per stage, with a zero-direction product path and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic signed [rbst_pkg::CRD_W-1:0]      corner,
	input  wire logic signed [rbst_pkg::CRD_W-1:0]      origin,
	input  wire logic signed [rbst_pkg::CRD_W-1:0]      dir,
	output logic signed [rbst_pkg::DIST_W-1:0]          t
);

	localparam int NUM_W  = rbst_pkg::NUM_W;
	localparam int CRD_W  = rbst_pkg::CRD_W;
	localparam int ABS_W  = rbst_pkg::ABS_W;
	localparam int FRAC_W = rbst_pkg::FRAC_W;
	localparam int DIST_W = rbst_pkg::DIST_W;
	localparam int PROD_W = rbst_pkg::PROD_W;

	// divisor magnitude; the user must keep dir stable while items are in flight, the block does not enforce it
	logic [CRD_W-1:0] m;
	assign m = dir[CRD_W-1] ? CRD_W'(-dir) : CRD_W'(dir);

	// stage registers, index 0 is the operand stage
	logic [CRD_W-1:0]  rem_s  [0:NUM_W];
	logic [NUM_W-1:0]  num_s  [0:NUM_W];
	logic [NUM_W-1:0]  quo_s  [0:NUM_W];
	logic              neg_s  [0:NUM_W];
	logic              zdir_s [0:NUM_W];
	logic [DIST_W-2:0] zq_s   [1:NUM_W];

	// operand stage: exact difference and its magnitude
	logic signed [ABS_W-1:0] diff;
	logic [ABS_W-1:0]        diff_abs;
	assign diff     = ABS_W'(corner) - ABS_W'(origin);
	assign diff_abs = diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			num_s[0]  <= {diff_abs, {FRAC_W{1'b0}}};
			quo_s[0]  <= '0;
			neg_s[0]  <= diff[ABS_W-1] ^ dir[CRD_W-1];
			zdir_s[0] <= (dir == '0);
		end
	end

	// zero direction: magnitude times the largest distance, truncated
	logic [ABS_W-1:0]  a0;
	logic [PROD_W-1:0] zprod;
	logic [DIST_W-2:0] zq0;
	assign a0    = num_s[0][NUM_W-1:FRAC_W];
	assign zprod = PROD_W'(a0[FRAC_W-1:0]) * PROD_W'(rbst_pkg::DMAX);
	assign zq0   = (a0[ABS_W-1:FRAC_W] != '0) ? rbst_pkg::DMAX
	                                           : zprod[PROD_W-1:FRAC_W];

	// divider stages
	for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
		logic [CRD_W:0] trial;
		logic [CRD_W:0] sub;
		logic           ge;
		assign trial = {rem_s[k-1], num_s[k-1][NUM_W-1]};
		assign sub   = trial - {1'b0, m};
		assign ge    = ~sub[CRD_W];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? sub[CRD_W-1:0] : trial[CRD_W-1:0];
				num_s[k]  <= {num_s[k-1][NUM_W-2:0], 1'b0};
				quo_s[k]  <= {quo_s[k-1][NUM_W-2:0], ge};
				neg_s[k]  <= neg_s[k-1];
				zdir_s[k] <= zdir_s[k-1];
				zq_s[k]   <= (k == 1) ? zq0 : zq_s[k-1 > 0 ? k-1 : 1];
			end
		end
	end

	// saturate and apply sign
	logic [DIST_W-2:0] mag;
	always_comb begin
		if (zdir_s[NUM_W])
			mag = zq_s[NUM_W];
		else if (quo_s[NUM_W] > NUM_W'(rbst_pkg::DMAX))
			mag = rbst_pkg::DMAX;
		else
			mag = quo_s[NUM_W][DIST_W-2:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t <= neg_s[NUM_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

`default_nettype wire

@@ design/rbst_axis.sv @@
// ----------------------------------------------------------------------------
// rbst_axis
// One axis lane: both corner distances side by side, then ordered so the
// entry crossing comes first.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_axis (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [rbst_pkg::CRD_W-1:0] corner_min,
	input  wire logic signed [rbst_pkg::CRD_W-1:0] corner_max,
	input  wire logic signed [rbst_pkg::CRD_W-1:0] origin,
	input  wire logic signed [rbst_pkg::CRD_W-1:0] dir,
	output rbst_pkg::slab_t                        slab
);

	logic signed [rbst_pkg::DIST_W-1:0] t0, t1;

	rbst_div u_div_min (
		.clk    (clk),
		.en     (en),
		.corner (corner_min),
		.origin (origin),
		.dir    (dir),
		.t      (t0)
	);

	rbst_div u_div_max (
		.clk    (clk),
		.en     (en),
		.corner (corner_max),
		.origin (origin),
		.dir    (dir),
		.t      (t1)
	);

	// order the pair
	always_ff @(posedge clk) begin
		if (en) begin
			slab.t_lo <= (t0 > t1) ? t1 : t0;
			slab.t_hi <= (t0 > t1) ? t0 : t1;
		end
	end

endmodule

`default_nettype wire

@@ design/rbst_merge.sv @@
// ----------------------------------------------------------------------------
// rbst_merge
// Combines the three axis lanes: narrows the interval, then forms the hit
// and range flags into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_merge (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire rbst_pkg::slab_t                    slab_x,
	input  wire rbst_pkg::slab_t                    slab_y,
	input  wire rbst_pkg::slab_t                    slab_z,
	input  wire logic signed [rbst_pkg::DIST_W-1:0] max_distance,
	output rbst_pkg::res_t                          res
);

	logic signed [rbst_pkg::DIST_W-1:0] ent_xy, ext_xy;
	logic signed [rbst_pkg::DIST_W-1:0] enter_s1, exit_s1;

	// latest entry and earliest exit over the lanes
	assign ent_xy = (slab_x.t_lo > slab_y.t_lo) ? slab_x.t_lo : slab_y.t_lo;
	assign ext_xy = (slab_x.t_hi < slab_y.t_hi) ? slab_x.t_hi : slab_y.t_hi;

	always_ff @(posedge clk) begin
		if (en) begin
			enter_s1 <= (ent_xy > slab_z.t_lo) ? ent_xy : slab_z.t_lo;
			exit_s1  <= (ext_xy < slab_z.t_hi) ? ext_xy : slab_z.t_hi;
		end
	end

	// hit and first positive crossing against the range limit
	logic hit, in_range;
	always_comb begin
		hit      = enter_s1 < exit_s1;
		in_range = 1'b0;
		if (hit) begin
			if (enter_s1 > 0)
				in_range = enter_s1 < max_distance;
			else if (exit_s1 > 0)
				in_range = exit_s1 < max_distance;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.box_hit      <= hit;
			res.hit_in_range <= in_range;
			res.t_enter      <= enter_s1;
			res.t_exit       <= exit_s1;
		end
	end

endmodule

`default_nettype wire

@@ design/ray_box_slab_test_top.sv @@
// Throughput: one box per cycle unless a waiting result is stalled; each axis lane
// runs two dividers that resolve one quotient bit per pipeline stage.
// The whole pipeline advances unless a waiting result is stalled.
// Reset clears the valid pipeline and loads the default ray (x direction).
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray against axis-aligned box slab test, three axis lanes and a merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire rbst_pkg::box_t                      in_box,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output rbst_pkg::res_t                           out_res,
	input  wire logic                                cfg_we,
	input  wire logic [rbst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rbst_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LAT   = rbst_pkg::LAT;
	localparam int CRD_W = rbst_pkg::CRD_W;

	// ray registers
	logic signed [CRD_W-1:0]            org_x_q, org_y_q, org_z_q;
	logic signed [CRD_W-1:0]            dir_x_q, dir_y_q, dir_z_q;
	logic signed [rbst_pkg::DIST_W-1:0] max_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q    <= '0;
			org_y_q    <= '0;
			org_z_q    <= '0;
			dir_x_q    <= rbst_pkg::ONE;
			dir_y_q    <= '0;
			dir_z_q    <= '0;
			max_dist_q <= $signed({1'b0, rbst_pkg::DMAX});
		end else if (cfg_we) begin
			case (rbst_pkg::cfg_reg_t'(cfg_index))
				rbst_pkg::REG_ORIGIN_X: org_x_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_ORIGIN_Y: org_y_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_ORIGIN_Z: org_z_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_DIR_X:    dir_x_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_DIR_Y:    dir_y_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_DIR_Z:    dir_z_q    <= cfg_data[CRD_W-1:0];
				rbst_pkg::REG_MAX_DIST: max_dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance and valid tracking
	logic [LAT-1:0] vld_q;
	logic           adv;

	assign adv       = ~(vld_q[LAT-1] & out_stall);
	assign in_stall  = ~adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// axis lanes
	rbst_pkg::slab_t slab_x, slab_y, slab_z;

	rbst_axis u_axis_x (
		.clk        (clk),
		.en         (adv),
		.corner_min (in_box.box_min_x),
		.corner_max (in_box.box_max_x),
		.origin     (org_x_q),
		.dir        (dir_x_q),
		.slab       (slab_x)
	);

	rbst_axis u_axis_y (
		.clk        (clk),
		.en         (adv),
		.corner_min (in_box.box_min_y),
		.corner_max (in_box.box_max_y),
		.origin     (org_y_q),
		.dir        (dir_y_q),
		.slab       (slab_y)
	);

	rbst_axis u_axis_z (
		.clk        (clk),
		.en         (adv),
		.corner_min (in_box.box_min_z),
		.corner_max (in_box.box_max_z),
		.origin     (org_z_q),
		.dir        (dir_z_q),
		.slab       (slab_z)
	);

	// merge into the output register
	rbst_merge u_merge (
		.clk          (clk),
		.en           (adv),
		.slab_x       (slab_x),
		.slab_y       (slab_y),
		.slab_z       (slab_z),
		.max_distance (max_dist_q),
		.res          (out_res)
	);

	// checks
	a_range_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.box_hit || !out_res.hit_in_range))
		else $error("in-range flag without a hit");

	a_hit_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.box_hit == (out_res.t_enter < out_res.t_exit)))
		else $error("hit flag disagrees with interval");

	a_enter_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.t_enter != {1'b1, {(rbst_pkg::DIST_W-1){1'b0}}}))
		else $error("entry distance beyond saturation");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_res)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
